[rtl/half_float_convert_defines.svh]
// Assertion macros for the binary16/binary32 conversion block.
// Used by half_float_convert.sv; expects signals clk and rst_n in scope.
`ifndef HALF_FLOAT_CONVERT_DEFINES_SVH
`define HALF_FLOAT_CONVERT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("half_float_convert: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("half_float_convert: next-cycle check failed");

`endif

[rtl/hfc_pkg.sv]
// Shared types and constants for the binary16/binary32 conversion block.
// No dependencies; used by hfc_convert and half_float_convert.
`default_nettype none

package hfc_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic
    {
        REQ_S2H = 1'b0,
        REQ_H2S = 1'b1
    } req_t;

    localparam logic [14:0] HALF_QNAN     = 15'h7e00;
    localparam logic [14:0] HALF_INF      = 15'h7c00;
    localparam logic [7:0]  SINGLE_EXP_MAX = 8'hff;
    localparam logic [4:0]  HALF_EXP_MAX   = 5'h1f;

    // Single exponent limits for the half ranges.
    localparam logic [7:0]  S2H_EXP_OVF   = 8'd143;
    localparam logic [7:0]  S2H_EXP_NORM  = 8'd113;
    localparam logic [7:0]  S2H_EXP_TINY  = 8'd102;
    localparam logic [7:0]  S2H_SUB_BASE  = 8'd126;
    localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;
    localparam logic [7:0]  H2S_SUB_BASE  = 8'd103;

endpackage

`default_nettype wire

[rtl/half_float_convert.sv]
// An accepted item is held in the input register and its result in the
// result register. Throughput: one item per cycle without output stalls;
// the conversion logic between the two registers sets the clock period.
// Reset: rst_n clears both valid flags asynchronously; data registers keep
// their contents. The block holds no other state.
// Top level of the binary16/binary32 conversion block; uses hfc_pkg,
// hfc_convert and half_float_convert_defines.svh.
`default_nettype none

module half_float_convert
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [hfc_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] operand
    input  wire                          s_axis_tuser,   // [0] req_type
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [hfc_pkg::DATA_W-1:0]   m_axis_tdata    // [31:0] result
);

`include "half_float_convert_defines.svh"

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    hfc_pkg::req_t               s1_req_reg;
    logic [hfc_pkg::DATA_W-1:0]  s1_operand_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [hfc_pkg::DATA_W-1:0]  out_data_reg;
    logic [hfc_pkg::DATA_W-1:0]  conv_result;
    logic                        in_accept;
    logic                        out_load;

    assign out_load      = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    hfc_convert u_convert
    (
        .req_type (s1_req_reg),
        .operand  (s1_operand_reg),
        .result   (conv_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg     <= hfc_pkg::req_t'(s_axis_tuser);
            s1_operand_reg <= s_axis_tdata;
        end
        if (out_load)
        begin
            out_data_reg <= conv_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `HFC_ASSERT_NEXT(a_in_fill, s_axis_tvalid && s_axis_tready, s1_valid_reg)
    `HFC_ASSERT_NEXT(a_out_fill, s1_valid_reg && out_load, m_axis_tvalid)
    `HFC_ASSERT_NEXT(a_half_upper_zero, out_load && (s1_req_reg == hfc_pkg::REQ_S2H),
                     m_axis_tdata[31:16] == 16'b0)
    `HFC_ASSERT_SAME(a_empty_ready, !s1_valid_reg, s_axis_tready)

endmodule

`default_nettype wire

[rtl/hfc_convert.sv]
// Combinational binary32-to-binary16 and binary16-to-binary32 conversion.
// Depends on hfc_pkg for request codes and format constants.
`default_nettype none

module hfc_convert
(
    input  wire hfc_pkg::req_t              req_type,
    input  wire [hfc_pkg::DATA_W-1:0]       operand,
    output logic [hfc_pkg::DATA_W-1:0]      result
);

    logic        s_sign;
    logic [7:0]  s_exp;
    logic [22:0] s_man;
    logic [7:0]  sub_diff;
    logic [4:0]  sub_sh;
    logic [47:0] sub_shifted;
    logic [9:0]  sub_q;
    logic        sub_round;
    logic [10:0] sub_half;
    logic [7:0]  norm_diff;
    logic        norm_round;
    logic [14:0] norm_half;
    logic [15:0] half_res;

    logic        h_sign;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [3:0]  h_msb;
    logic [3:0]  h_norm_sh;
    logic [9:0]  h_sub_man;
    logic [7:0]  h_sub_exp;
    logic [7:0]  h_norm_exp;
    logic [31:0] single_res;

    assign s_sign = operand[31];
    assign s_exp  = operand[30:23];
    assign s_man  = operand[22:0];

    // Half subnormal path: shift the full significand right and round to even.
    assign sub_diff    = hfc_pkg::S2H_SUB_BASE - s_exp;
    assign sub_sh      = sub_diff[4:0];
    assign sub_shifted = {1'b1, s_man, 24'b0} >> sub_sh;
    assign sub_q       = sub_shifted[33:24];
    assign sub_round   = sub_shifted[23] && ((|sub_shifted[22:0]) || sub_q[0]);
    assign sub_half    = {1'b0, sub_q} + {10'b0, sub_round};

    // Half normal path: a mantissa carry moves into the exponent, up to infinity.
    assign norm_diff  = s_exp - hfc_pkg::EXP_BIAS_DIFF;
    assign norm_round = s_man[12] && ((|s_man[11:0]) || s_man[13]);
    assign norm_half  = {norm_diff[4:0], s_man[22:13]} + {14'b0, norm_round};

    always_comb
    begin
        if (s_exp == hfc_pkg::SINGLE_EXP_MAX)
        begin
            half_res = {s_sign, (s_man != 23'b0) ? hfc_pkg::HALF_QNAN : hfc_pkg::HALF_INF};
        end
        else if (s_exp >= hfc_pkg::S2H_EXP_OVF)
        begin
            half_res = {s_sign, hfc_pkg::HALF_INF};
        end
        else if (s_exp < hfc_pkg::S2H_EXP_TINY)
        begin
            half_res = {s_sign, 15'b0};
        end
        else if (s_exp < hfc_pkg::S2H_EXP_NORM)
        begin
            half_res = {s_sign, 4'b0, sub_half};
        end
        else
        begin
            half_res = {s_sign, norm_half};
        end
    end

    assign h_sign = operand[15];
    assign h_exp  = operand[14:10];
    assign h_man  = operand[9:0];

    always_comb
    begin
        h_msb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (h_man[i])
            begin
                h_msb = 4'(i);
            end
        end
    end

    // A half subnormal is normalized so that its leading one becomes implicit.
    assign h_norm_sh  = 4'd10 - h_msb;
    assign h_sub_man  = h_man << h_norm_sh;
    assign h_sub_exp  = hfc_pkg::H2S_SUB_BASE + {4'b0, h_msb};
    assign h_norm_exp = {3'b0, h_exp} + hfc_pkg::EXP_BIAS_DIFF;

    always_comb
    begin
        if (h_exp == 5'b0)
        begin
            if (h_man == 10'b0)
            begin
                single_res = {h_sign, 31'b0};
            end
            else
            begin
                single_res = {h_sign, h_sub_exp, h_sub_man, 13'b0};
            end
        end
        else if (h_exp == hfc_pkg::HALF_EXP_MAX)
        begin
            single_res = {h_sign, hfc_pkg::SINGLE_EXP_MAX, h_man, 13'b0};
        end
        else
        begin
            single_res = {h_sign, h_norm_exp, h_man, 13'b0};
        end
    end

    always_comb
    begin
        case (req_type)
            hfc_pkg::REQ_S2H: result = {16'b0, half_res};
            hfc_pkg::REQ_H2S: result = single_res;
            default:          result = single_res;
        endcase
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for half_float_convert: binary32 <-> binary16 conversions
// are streamed through the block and each result is compared with a local predictor.
// Depends on hfc_pkg and the half_float_convert RTL.
module testbench;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed
    {
        hfc_pkg::req_t                kind;
        logic [hfc_pkg::DATA_W-1:0]   operand;
    } conv_item_t;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [hfc_pkg::DATA_W-1:0]   s_axis_tdata  = '0;
    logic                         s_axis_tuser  = hfc_pkg::REQ_S2H;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [hfc_pkg::DATA_W-1:0]   m_axis_tdata;

    conv_item_t                   pending_items[$];
    logic [hfc_pkg::DATA_W-1:0]   expected_results[$];
    conv_item_t                   next_item;
    logic [hfc_pkg::DATA_W-1:0]   want;
    int                           cycle_cnt   = 0;
    int                           err_cnt     = 0;
    int                           n_to_half   = 0;
    int                           n_to_single = 0;
    int                           n_checked   = 0;

    half_float_convert u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] round_to_half(logic [31:0] bits);
        logic [15:0] sgn;
        logic [31:0] mant;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] halfway;
        int          hexp;
        int          sh;
        sgn  = {bits[31], 15'b0};
        mant = {9'b0, bits[22:0]};
        if (bits[30:23] == hfc_pkg::SINGLE_EXP_MAX)
            return {16'b0, sgn | {1'b0, (mant != 0) ? hfc_pkg::HALF_QNAN : hfc_pkg::HALF_INF}};
        hexp = int'(bits[30:23]) - 112;
        if (hexp >= 31)
            return {16'b0, sgn | {1'b0, hfc_pkg::HALF_INF}};
        if (hexp <= 0)
        begin
            if (hexp < -10)
                return {16'b0, sgn};
            mant    = mant | 32'h0080_0000;
            sh      = 14 - hexp;
            q       = mant >> sh;
            rem     = mant & ((32'd1 << sh) - 1);
            halfway = 32'd1 << (sh - 1);
            if (rem > halfway || (rem == halfway && q[0]))
                q = q + 1;
            return {16'b0, sgn | q[15:0]};
        end
        q   = mant >> 13;
        rem = mant & 32'h1fff;
        if (rem > 32'h1000 || (rem == 32'h1000 && q[0]))
        begin
            q = q + 1;
            if (q == 32'h400)
            begin
                q    = 0;
                hexp = hexp + 1;
                if (hexp >= 31)
                    return {16'b0, sgn | {1'b0, hfc_pkg::HALF_INF}};
            end
        end
        return {16'b0, sgn | (16'(hexp) << 10) | q[15:0]};
    endfunction

    function automatic logic [31:0] widen_to_single(logic [15:0] h);
        logic [31:0] sgn;
        logic [10:0] mant;
        int          sh;
        sgn  = {h[15], 31'b0};
        mant = {1'b0, h[9:0]};
        sh   = 0;
        if (h[14:10] == 5'd0)
        begin
            if (mant == 0)
                return sgn;
            while (!mant[10] && sh < 11)
            begin
                mant = mant << 1;
                sh++;
            end
            return sgn | (32'(113 - sh) << 23) | (32'(mant[9:0]) << 13);
        end
        if (h[14:10] == hfc_pkg::HALF_EXP_MAX)
            return sgn | 32'h7f80_0000 | (32'(mant[9:0]) << 13);
        return sgn | ((32'(h[14:10]) + 32'd112) << 23) | (32'(mant[9:0]) << 13);
    endfunction

    function automatic logic [31:0] convert_item(conv_item_t it);
        if (it.kind == hfc_pkg::REQ_S2H)
            return round_to_half(it.operand);
        return widen_to_single(it.operand[15:0]);
    endfunction

    // Random stalls, except for a stretch where both sides run flat out.
    function automatic logic take_break();
        if (cycle_cnt >= 600 && cycle_cnt < 1000)
            return 1'b0;
        return $urandom_range(0, 99) < 11;
    endfunction

    task automatic add_item(hfc_pkg::req_t kind, logic [31:0] operand);
        conv_item_t it;
        it.kind    = kind;
        it.operand = operand;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [31:0] random_single();
        logic [31:0] bits;
        logic [31:0] mant;
        int          k;
        bits = $urandom();
        case ($urandom_range(0, 9))
            0, 1: ;
            2, 3, 4, 5, 6:
                bits[30:23] = 8'($urandom_range(98, 146));
            7:
            begin
                k           = $urandom_range(13, 24);
                mant        = ($urandom() & ~((32'd1 << k) - 1)) | (32'd1 << (k - 1));
                bits[22:0]  = mant[22:0];
                bits[30:23] = 8'($urandom_range(100, 143));
            end
            8:
            begin
                bits[30:23] = $urandom_range(0, 1) ? hfc_pkg::SINGLE_EXP_MAX : 8'd0;
                if ($urandom_range(0, 3) == 0)
                    bits[22:0] = '0;
            end
            default:
            begin
                bits[22:0]  = 23'h7f_ffff - 23'($urandom_range(0, 4095));
                bits[30:23] = 8'($urandom_range(100, 145));
            end
        endcase
        return bits;
    endfunction

    function automatic logic [31:0] random_half();
        logic [31:0] bits;
        bits = $urandom();
        case ($urandom_range(0, 5))
            0: bits[14:10] = 5'd0;
            1: bits[14:10] = hfc_pkg::HALF_EXP_MAX;
            2: bits[9:0]   = '0;
            default: ;
        endcase
        return bits;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= hfc_pkg::REQ_S2H;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_item.kind    = hfc_pkg::req_t'(s_axis_tuser);
                next_item.operand = s_axis_tdata;
                expected_results.insert(expected_results.size(), convert_item(next_item));
                if (next_item.kind == hfc_pkg::REQ_S2H)
                    n_to_half++;
                else
                    n_to_single++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() > 0 && !take_break())
                begin
                    next_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.operand;
                    s_axis_tuser  <= next_item.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result: unexpected item %h", m_axis_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (m_axis_tdata !== want)
                    begin
                        $error("result: expected %h, actual %h", want, m_axis_tdata);
                        err_cnt++;
                    end
                end
            end
            m_axis_tready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        // Zeros, infinities, NaNs and overflow.
        add_item(hfc_pkg::REQ_S2H, 32'h0000_0000);
        add_item(hfc_pkg::REQ_S2H, 32'h8000_0000);
        add_item(hfc_pkg::REQ_S2H, 32'h7f80_0000);
        add_item(hfc_pkg::REQ_S2H, 32'hff80_0000);
        add_item(hfc_pkg::REQ_S2H, 32'h7fc0_0001);
        add_item(hfc_pkg::REQ_S2H, 32'hff80_0001);
        add_item(hfc_pkg::REQ_S2H, 32'h7f7f_ffff);
        add_item(hfc_pkg::REQ_S2H, 32'h477f_e000);
        add_item(hfc_pkg::REQ_S2H, 32'h477f_f000);
        // Subnormal results, underflow and single subnormal inputs.
        add_item(hfc_pkg::REQ_S2H, 32'h3380_0000);
        add_item(hfc_pkg::REQ_S2H, 32'h3300_0000);
        add_item(hfc_pkg::REQ_S2H, 32'h3300_0001);
        add_item(hfc_pkg::REQ_S2H, 32'h0000_0001);
        add_item(hfc_pkg::REQ_S2H, 32'h807f_ffff);
        add_item(hfc_pkg::REQ_S2H, 32'h387f_f000);
        // Ties to even in the normal range, then half-to-single conversions.
        add_item(hfc_pkg::REQ_S2H, 32'h3f80_1000);
        add_item(hfc_pkg::REQ_S2H, 32'h3f80_3000);
        add_item(hfc_pkg::REQ_H2S, 32'h0000_0000);
        add_item(hfc_pkg::REQ_H2S, 32'h0000_8000);
        add_item(hfc_pkg::REQ_H2S, 32'h0000_0001);
        add_item(hfc_pkg::REQ_H2S, 32'h0000_83ff);
        add_item(hfc_pkg::REQ_H2S, 32'h0000_7c00);
        add_item(hfc_pkg::REQ_H2S, 32'h0000_fc00);
        add_item(hfc_pkg::REQ_H2S, 32'h0000_7c01);
        add_item(hfc_pkg::REQ_H2S, 32'hdead_7bff);
        add_item(hfc_pkg::REQ_H2S, 32'hffff_0400);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 1))
                add_item(hfc_pkg::REQ_S2H, random_single());
            else
                add_item(hfc_pkg::REQ_H2S, random_half());
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results: %0d single-to-half and %0d half-to-single items.",
                 n_checked, n_to_half, n_to_single);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
